// File: src/fdsa_pkg.sv
package fdsa_pkg;

  // Fixed field widths of the transaction ports
  localparam int NAME_W       = 48;
  localparam int NAME_BYTES   = 6;
  localparam int COUNT_W      = 5;
  localparam int SECTOR_W     = 9;
  localparam int STATUS_W     = 3;

  // Sector numbers must fit in SECTOR_W bits
  localparam int SECTOR_LIMIT = 512;
  // Sectors 0..2 are reserved at reset
  localparam int RESERVED     = 3;

  // Request function codes
  localparam logic FUNC_LOOKUP = 1'b0;
  localparam logic FUNC_CREATE = 1'b1;

  // Result status codes
  typedef enum logic [STATUS_W-1:0] {
    ST_SECTOR    = 3'd0,
    ST_NONE      = 3'd1,
    ST_NOT_FOUND = 3'd2,
    ST_NO_SPACE  = 3'd3,
    ST_DIR_FULL  = 3'd4
  } status_t;

  // Controller states
  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_RD   = 4'b0010,
    S_CHK  = 4'b0100,
    S_EMIT = 4'b1000
  } state_t;

  // Directory memory strobes
  typedef struct packed {
    logic rd_en;
    logic wr_en;
  } dir_ctl_t;

endpackage

// File: src/fdsa_dir.sv
module fdsa_dir #(
  parameter int DIR_ENTRIES = 16,
  parameter int BASE_W      = 10
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  fdsa_pkg::dir_ctl_t              ctl,
  input  logic [$clog2(DIR_ENTRIES)-1:0]  rd_addr,
  input  logic [$clog2(DIR_ENTRIES)-1:0]  wr_addr,
  input  logic [fdsa_pkg::NAME_W-1:0]     wr_name,
  input  logic [BASE_W-1:0]               wr_base,
  input  logic [fdsa_pkg::COUNT_W-1:0]    wr_cnt,
  output logic [fdsa_pkg::NAME_W-1:0]     rd_name,
  output logic [BASE_W-1:0]               rd_base,
  output logic [fdsa_pkg::COUNT_W-1:0]    rd_cnt
);

  localparam int ENTRY_W = fdsa_pkg::NAME_W + BASE_W + fdsa_pkg::COUNT_W;

  // Each entry holds a name and its contiguous sector run (first sector, length)
  logic [ENTRY_W-1:0]     mem [DIR_ENTRIES];
  logic [DIR_ENTRIES-1:0] valid_r;
  logic [ENTRY_W-1:0]     rd_data_r;
  logic                   rd_hit_r;

  // Memory array: one write and one registered read port
  always_ff @(posedge clk) begin
    if (ctl.wr_en) begin
      mem[wr_addr] <= {wr_name, wr_base, wr_cnt};
    end
    if (ctl.rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  // Per-entry written flags; an unwritten entry reads as all zero
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r  <= '0;
      rd_hit_r <= 1'b0;
    end else begin
      if (ctl.wr_en) begin
        valid_r[wr_addr] <= 1'b1;
      end
      if (ctl.rd_en) begin
        rd_hit_r <= valid_r[rd_addr];
      end
    end
  end

  assign {rd_name, rd_base, rd_cnt} = rd_hit_r ? rd_data_r : '0;

endmodule

// File: src/fdsa_ctrl.sv
module fdsa_ctrl #(
  parameter int SPAN             = 512,
  parameter int DIR_ENTRIES      = 16,
  parameter int NAME_CHARS       = 6,
  parameter int SECTORS_PER_FILE = 26,
  parameter int BASE_W           = 10
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            start,
  output logic                            busy,
  input  logic                            in_func,
  input  logic [fdsa_pkg::NAME_W-1:0]     in_file_name,
  input  logic [fdsa_pkg::COUNT_W-1:0]    in_sector_count,
  output logic                            out_valid,
  output logic [fdsa_pkg::SECTOR_W-1:0]   out_sector,
  output logic [fdsa_pkg::STATUS_W-1:0]   out_status,
  output logic                            out_last,
  output fdsa_pkg::dir_ctl_t              dir_ctl,
  output logic [$clog2(DIR_ENTRIES)-1:0]  dir_addr,
  output logic [fdsa_pkg::NAME_W-1:0]     dir_wr_name,
  output logic [BASE_W-1:0]               dir_wr_base,
  output logic [fdsa_pkg::COUNT_W-1:0]    dir_wr_cnt,
  input  logic [fdsa_pkg::NAME_W-1:0]     dir_rd_name,
  input  logic [BASE_W-1:0]               dir_rd_base,
  input  logic [fdsa_pkg::COUNT_W-1:0]    dir_rd_cnt
);

  localparam int ADDR_W = $clog2(DIR_ENTRIES);

  fdsa_pkg::state_t                 state_r, state_nxt;
  logic                             func_r, func_nxt;
  logic [fdsa_pkg::NAME_W-1:0]      req_r, req_nxt;
  logic [fdsa_pkg::NAME_W-1:0]      mask_r, mask_nxt;
  logic [fdsa_pkg::COUNT_W-1:0]     count_r, count_nxt;
  logic [ADDR_W-1:0]                idx_r, idx_nxt;
  logic [BASE_W-1:0]                next_r, next_nxt;
  logic [BASE_W-1:0]                sec_r, sec_nxt;
  logic [fdsa_pkg::COUNT_W-1:0]     left_r, left_nxt;
  logic                             ov_r, ov_nxt;
  logic [fdsa_pkg::SECTOR_W-1:0]    osec_r, osec_nxt;
  fdsa_pkg::status_t                ost_r, ost_nxt;
  logic                             olast_r, olast_nxt;

  logic [fdsa_pkg::NAME_W-1:0]      name_msk;
  logic                             run;
  logic [BASE_W-1:0]                avail;
  logic                             too_many;
  logic                             name_hit;
  logic                             slot_free;
  logic                             idx_end;

  // Significant name bytes: up to the first zero byte or NAME_CHARS bytes
  always_comb begin
    run      = 1'b1;
    name_msk = '0;
    for (int i = 0; i < fdsa_pkg::NAME_BYTES; i++) begin
      if (i >= NAME_CHARS || in_file_name[8*i +: 8] == 8'h00) begin
        run = 1'b0;
      end
      if (run) begin
        name_msk[8*i +: 8] = 8'hFF;
      end
    end
  end

  // Space check; free sectors are always the range next_r..SPAN-1
  assign avail    = BASE_W'(SPAN) - next_r;
  assign too_many = (BASE_W'(in_sector_count) > avail) ||
                    (int'(in_sector_count) > SECTORS_PER_FILE);

  // Directory entry tests on the registered read data
  assign name_hit  = (dir_rd_name & mask_r) == req_r;
  assign slot_free = dir_rd_name[7:0] == 8'h00;
  assign idx_end   = idx_r == ADDR_W'(DIR_ENTRIES - 1);

  // Directory port: scan address doubles as the write address
  assign dir_addr    = idx_r;
  assign dir_wr_name = req_r;
  assign dir_wr_base = next_r;
  assign dir_wr_cnt  = count_r;

  // Sequencer
  always_comb begin
    state_nxt = state_r;
    func_nxt  = func_r;
    req_nxt   = req_r;
    mask_nxt  = mask_r;
    count_nxt = count_r;
    idx_nxt   = idx_r;
    next_nxt  = next_r;
    sec_nxt   = sec_r;
    left_nxt  = left_r;
    ov_nxt    = 1'b0;
    osec_nxt  = '0;
    ost_nxt   = fdsa_pkg::ST_SECTOR;
    olast_nxt = 1'b0;
    dir_ctl   = '0;
    case (state_r)
      fdsa_pkg::S_IDLE: begin
        if (start) begin
          func_nxt  = in_func;
          req_nxt   = in_file_name & name_msk;
          mask_nxt  = name_msk;
          count_nxt = in_sector_count;
          idx_nxt   = '0;
          if (in_func == fdsa_pkg::FUNC_CREATE && too_many) begin
            ov_nxt    = 1'b1;
            ost_nxt   = fdsa_pkg::ST_NO_SPACE;
            olast_nxt = 1'b1;
          end else begin
            state_nxt = fdsa_pkg::S_RD;
          end
        end
      end
      fdsa_pkg::S_RD: begin
        dir_ctl.rd_en = 1'b1;
        state_nxt     = fdsa_pkg::S_CHK;
      end
      fdsa_pkg::S_CHK: begin
        if (func_r == fdsa_pkg::FUNC_LOOKUP) begin
          if (name_hit) begin
            if (dir_rd_cnt == '0) begin
              ov_nxt    = 1'b1;
              ost_nxt   = fdsa_pkg::ST_NONE;
              olast_nxt = 1'b1;
              state_nxt = fdsa_pkg::S_IDLE;
            end else begin
              sec_nxt   = dir_rd_base;
              left_nxt  = dir_rd_cnt;
              state_nxt = fdsa_pkg::S_EMIT;
            end
          end else if (idx_end) begin
            ov_nxt    = 1'b1;
            ost_nxt   = fdsa_pkg::ST_NOT_FOUND;
            olast_nxt = 1'b1;
            state_nxt = fdsa_pkg::S_IDLE;
          end else begin
            idx_nxt   = idx_r + 1'b1;
            state_nxt = fdsa_pkg::S_RD;
          end
        end else begin
          if (slot_free) begin
            // Claim the slot and the next count_r sectors
            dir_ctl.wr_en = 1'b1;
            next_nxt      = next_r + BASE_W'(count_r);
            if (count_r == '0) begin
              ov_nxt    = 1'b1;
              ost_nxt   = fdsa_pkg::ST_NONE;
              olast_nxt = 1'b1;
              state_nxt = fdsa_pkg::S_IDLE;
            end else begin
              sec_nxt   = next_r;
              left_nxt  = count_r;
              state_nxt = fdsa_pkg::S_EMIT;
            end
          end else if (idx_end) begin
            ov_nxt    = 1'b1;
            ost_nxt   = fdsa_pkg::ST_DIR_FULL;
            olast_nxt = 1'b1;
            state_nxt = fdsa_pkg::S_IDLE;
          end else begin
            idx_nxt   = idx_r + 1'b1;
            state_nxt = fdsa_pkg::S_RD;
          end
        end
      end
      fdsa_pkg::S_EMIT: begin
        ov_nxt    = 1'b1;
        osec_nxt  = fdsa_pkg::SECTOR_W'(sec_r);
        olast_nxt = left_r == fdsa_pkg::COUNT_W'(1);
        sec_nxt   = sec_r + 1'b1;
        left_nxt  = left_r - 1'b1;
        if (left_r == fdsa_pkg::COUNT_W'(1)) begin
          state_nxt = fdsa_pkg::S_IDLE;
        end
      end
      default: begin
        state_nxt = fdsa_pkg::S_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= fdsa_pkg::S_IDLE;
      next_r  <= BASE_W'(fdsa_pkg::RESERVED);
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      next_r  <= next_nxt;
      ov_r    <= ov_nxt;
    end
  end

  // Request and result payload registers
  always_ff @(posedge clk) begin
    func_r  <= func_nxt;
    req_r   <= req_nxt;
    mask_r  <= mask_nxt;
    count_r <= count_nxt;
    idx_r   <= idx_nxt;
    sec_r   <= sec_nxt;
    left_r  <= left_nxt;
    osec_r  <= osec_nxt;
    ost_r   <= ost_nxt;
    olast_r <= olast_nxt;
  end

  assign busy       = state_r != fdsa_pkg::S_IDLE;
  assign out_valid  = ov_r;
  assign out_sector = osec_r;
  assign out_status = ost_r;
  assign out_last   = olast_r;

`ifndef SYNTHESIS
  // Allocation pointer never passes the end of the map
  a_next_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    next_r <= BASE_W'(SPAN))
    else $error("allocation pointer beyond sector map");

  // Emission always has results left
  a_emit_left: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == fdsa_pkg::S_EMIT |-> left_r != '0)
    else $error("emit state with no sectors left");

  // An accepted request either answers at once or starts the scan
  a_accept_path: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == fdsa_pkg::S_IDLE && start) |=> (ov_r || state_r == fdsa_pkg::S_RD))
    else $error("accepted request went nowhere");

  // Directory writes come only from a create check
  a_write_src: assert property (@(posedge clk) disable iff (!rst_n)
    dir_ctl.wr_en |-> (state_r == fdsa_pkg::S_CHK && func_r == fdsa_pkg::FUNC_CREATE))
    else $error("directory write outside create");

  // Any non-sector status is a lone, final result with a zero sector
  a_status_final: assert property (@(posedge clk) disable iff (!rst_n)
    (ov_r && ost_r != fdsa_pkg::ST_SECTOR) |-> (olast_r && osec_r == '0))
    else $error("error status not final or sector nonzero");
`endif

endmodule

// File: src/file_directory_sector_allocator_top.sv
// Results: an immediate refusal is registered and shows in the cycle after accept; each directory
//   slot is read in S_RD and tested in S_CHK, a status is registered from S_CHK, sectors from S_EMIT;
//   sector results then follow one per cycle.
// Requests are taken one at a time and none while busy; each directory slot is read from the
//   directory memory and then checked in turn.
// Results are strobed for one cycle on out_valid; the receiver cannot stall.
// Reset (rst_n, synchronous): directory entries read as empty, sectors 0-2 in use; no clear sweep.
module file_directory_sector_allocator_top #(
  parameter int MAP_SECTORS      = 512,
  parameter int DIR_ENTRIES      = 16,
  parameter int NAME_CHARS       = 6,
  parameter int SECTORS_PER_FILE = 26
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            start,
  output logic                            busy,
  input  logic                            in_func,
  input  logic [fdsa_pkg::NAME_W-1:0]     in_file_name,
  input  logic [fdsa_pkg::COUNT_W-1:0]    in_sector_count,
  output logic                            out_valid,
  output logic [fdsa_pkg::SECTOR_W-1:0]   out_sector,
  output logic [fdsa_pkg::STATUS_W-1:0]   out_status,
  output logic                            out_last
);

  localparam int SPAN   = (MAP_SECTORS < fdsa_pkg::SECTOR_LIMIT) ?
                          MAP_SECTORS : fdsa_pkg::SECTOR_LIMIT;
  localparam int BASE_W = $clog2(SPAN + 1);
  localparam int ADDR_W = $clog2(DIR_ENTRIES);

  fdsa_pkg::dir_ctl_t               dir_ctl;
  logic [ADDR_W-1:0]                dir_addr;
  logic [fdsa_pkg::NAME_W-1:0]      dir_wr_name;
  logic [BASE_W-1:0]                dir_wr_base;
  logic [fdsa_pkg::COUNT_W-1:0]     dir_wr_cnt;
  logic [fdsa_pkg::NAME_W-1:0]      dir_rd_name;
  logic [BASE_W-1:0]                dir_rd_base;
  logic [fdsa_pkg::COUNT_W-1:0]     dir_rd_cnt;

  // Request sequencer and sector allocation pointer
  fdsa_ctrl #(
    .SPAN             (SPAN),
    .DIR_ENTRIES      (DIR_ENTRIES),
    .NAME_CHARS       (NAME_CHARS),
    .SECTORS_PER_FILE (SECTORS_PER_FILE),
    .BASE_W           (BASE_W)
  ) u_ctrl (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .busy            (busy),
    .in_func         (in_func),
    .in_file_name    (in_file_name),
    .in_sector_count (in_sector_count),
    .out_valid       (out_valid),
    .out_sector      (out_sector),
    .out_status      (out_status),
    .out_last        (out_last),
    .dir_ctl         (dir_ctl),
    .dir_addr        (dir_addr),
    .dir_wr_name     (dir_wr_name),
    .dir_wr_base     (dir_wr_base),
    .dir_wr_cnt      (dir_wr_cnt),
    .dir_rd_name     (dir_rd_name),
    .dir_rd_base     (dir_rd_base),
    .dir_rd_cnt      (dir_rd_cnt)
  );

  // Directory memory
  fdsa_dir #(
    .DIR_ENTRIES (DIR_ENTRIES),
    .BASE_W      (BASE_W)
  ) u_dir (
    .clk     (clk),
    .rst_n   (rst_n),
    .ctl     (dir_ctl),
    .rd_addr (dir_addr),
    .wr_addr (dir_addr),
    .wr_name (dir_wr_name),
    .wr_base (dir_wr_base),
    .wr_cnt  (dir_wr_cnt),
    .rd_name (dir_rd_name),
    .rd_base (dir_rd_base),
    .rd_cnt  (dir_rd_cnt)
  );

endmodule

// File: tb/testbench.sv
`timescale 1ns / 100ps

module testbench;

  localparam int MAP            = 512;
  localparam int SLOTS          = 16;
  localparam int LIST_LEN       = 26;
  localparam int DIRECTED_ROWS  = 18;
  localparam int PHASE_ITEMS    = 110;
  localparam int DRAIN_CYCLES   = 80;
  localparam int WATCHDOG_LIMIT = 2000;

  // one result transaction: a sector of the file or a status code
  typedef struct packed {
    logic [fdsa_pkg::SECTOR_W-1:0] sector;
    fdsa_pkg::status_t             status;
    logic                          last;
  } sector_reply_t;

  // one row of the directed table; fixed rows carry their single expected status
  typedef struct packed {
    logic                         func;
    logic [fdsa_pkg::NAME_W-1:0]  name;
    logic [fdsa_pkg::COUNT_W-1:0] count;
    logic                         fixed;
    fdsa_pkg::status_t            status;
  } file_req_t;

  logic                          clk = 1'b0;
  logic                          rst_n = 1'b0;
  logic                          start = 1'b0;
  logic                          in_func = fdsa_pkg::FUNC_LOOKUP;
  logic [fdsa_pkg::NAME_W-1:0]   in_file_name = '0;
  logic [fdsa_pkg::COUNT_W-1:0]  in_sector_count = '0;
  logic                          busy;
  logic                          out_valid;
  logic [fdsa_pkg::SECTOR_W-1:0] out_sector;
  logic [fdsa_pkg::STATUS_W-1:0] out_status;
  logic                          out_last;

  // shadow copy of the allocator state
  logic                          map_used [MAP];
  logic [fdsa_pkg::NAME_W-1:0]   slot_name [SLOTS];
  logic [fdsa_pkg::SECTOR_W-1:0] slot_list [SLOTS][LIST_LEN];

  sector_reply_t sector_replies [$];
  sector_reply_t fresh_replies [$];
  sector_reply_t due;
  file_req_t     directed [DIRECTED_ROWS];
  int            mismatches = 0;
  int            quiet_cycles = 0;

  file_directory_sector_allocator_top u_top (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .busy            (busy),
    .in_func         (in_func),
    .in_file_name    (in_file_name),
    .in_sector_count (in_sector_count),
    .out_valid       (out_valid),
    .out_sector      (out_sector),
    .out_status      (out_status),
    .out_last        (out_last)
  );

  always #2 clk = ~clk;

  // request bytes up to the first zero must equal the stored bytes
  function automatic bit name_hit(logic [fdsa_pkg::NAME_W-1:0] stored,
                                  logic [fdsa_pkg::NAME_W-1:0] req);
    int i;
    for (i = 0; i < fdsa_pkg::NAME_BYTES; i++) begin
      if (req[8*i +: 8] == 8'h00) return 1'b1;
      if (stored[8*i +: 8] != req[8*i +: 8]) return 1'b0;
    end
    return 1'b1;
  endfunction

  // results of one request; updates the shadow state on a successful create
  function automatic void compute_sector_replies(logic f, logic [fdsa_pkg::NAME_W-1:0] nm,
                                                 logic [fdsa_pkg::COUNT_W-1:0] cnt);
    int s, j, slot, free_cnt, want;
    logic [fdsa_pkg::NAME_W-1:0] kept;
    fresh_replies.delete();
    slot = -1;
    if (f == fdsa_pkg::FUNC_LOOKUP) begin
      for (s = 0; s < SLOTS && slot < 0; s++)
        if (name_hit(slot_name[s], nm)) slot = s;
      if (slot < 0) begin
        fresh_replies.push_back('{'0, fdsa_pkg::ST_NOT_FOUND, 1'b1});
        return;
      end
      for (j = 0; j < LIST_LEN; j++) begin
        if (slot_list[slot][j] == '0) break;
        fresh_replies.push_back('{slot_list[slot][j], fdsa_pkg::ST_SECTOR, 1'b0});
      end
    end else begin
      want = cnt;
      free_cnt = 0;
      for (s = 0; s < MAP; s++)
        if (!map_used[s]) free_cnt++;
      // space check comes ahead of the slot check
      if (want > free_cnt || want > LIST_LEN) begin
        fresh_replies.push_back('{'0, fdsa_pkg::ST_NO_SPACE, 1'b1});
        return;
      end
      for (s = 0; s < SLOTS && slot < 0; s++)
        if (slot_name[s][7:0] == 8'h00) slot = s;
      if (slot < 0) begin
        fresh_replies.push_back('{'0, fdsa_pkg::ST_DIR_FULL, 1'b1});
        return;
      end
      // name is kept only up to its first zero byte
      kept = '0;
      for (j = 0; j < fdsa_pkg::NAME_BYTES; j++) begin
        if (nm[8*j +: 8] == 8'h00) break;
        kept[8*j +: 8] = nm[8*j +: 8];
      end
      slot_name[slot] = kept;
      for (j = 0; j < LIST_LEN; j++) slot_list[slot][j] = '0;
      // first fit, ascending
      j = 0;
      for (s = 0; s < MAP && j < want; s++) begin
        if (!map_used[s]) begin
          map_used[s] = 1'b1;
          slot_list[slot][j] = s[fdsa_pkg::SECTOR_W-1:0];
          j++;
          fresh_replies.push_back('{s[fdsa_pkg::SECTOR_W-1:0], fdsa_pkg::ST_SECTOR, 1'b0});
        end
      end
    end
    if (fresh_replies.size() == 0)
      fresh_replies.push_back('{'0, fdsa_pkg::ST_NONE, 1'b1});
    else
      fresh_replies[fresh_replies.size()-1].last = 1'b1;
  endfunction

  function automatic logic [fdsa_pkg::NAME_W-1:0] rand_name();
    logic [63:0] raw;
    raw = {$urandom(), $urandom()};
    return raw[fdsa_pkg::NAME_W-1:0];
  endfunction

  // random request: mostly lookups of stored names, empty-name creates that
  // drain the map, and named creates that fill the directory
  task automatic pick_random_request(output logic f, output logic [fdsa_pkg::NAME_W-1:0] nm,
                                     output logic [fdsa_pkg::COUNT_W-1:0] cnt);
    int r, m, k, i, v;
    r = $urandom_range(99);
    m = $urandom_range(99);
    k = $urandom_range(fdsa_pkg::NAME_BYTES - 1, 1);
    v = 0;
    if (r < 53) begin
      f = fdsa_pkg::FUNC_LOOKUP;
      nm = slot_name[$urandom_range(SLOTS - 1)];
      if (m < 20) begin
        // prefix with junk after the terminating zero
        nm[8*k +: 8] = 8'h00;
        for (i = k + 1; i < fdsa_pkg::NAME_BYTES; i++) nm[8*i +: 8] = 8'(rand_name());
      end else if (m < 35) begin
        nm[$urandom_range(fdsa_pkg::NAME_W - 1)] ^= 1'b1;
      end else if (m < 50) begin
        nm = rand_name();
      end
      v = $urandom_range(31);
    end else if (r < 88) begin
      f = fdsa_pkg::FUNC_CREATE;
      nm = rand_name();
      nm[7:0] = 8'h00;
      v = (m < 75) ? $urandom_range(26, 16) : $urandom_range(31);
    end else begin
      f = fdsa_pkg::FUNC_CREATE;
      nm = rand_name();
      v = $urandom_range(255, 1);
      nm[7:0] = v[7:0];
      if ($urandom_range(99) < 20) nm[8*k +: 8] = 8'h00;
      v = (m < 25) ? 0 : (m < 70) ? $urandom_range(8, 1) :
          (m < 85) ? $urandom_range(26, 9) : $urandom_range(31);
    end
    cnt = v[fdsa_pkg::COUNT_W-1:0];
  endtask

  // present one transaction, wait until the block is no longer busy, queue its results
  task automatic send_request(input logic f, input logic [fdsa_pkg::NAME_W-1:0] nm,
                              input logic [fdsa_pkg::COUNT_W-1:0] cnt, input int idle_pct,
                              input logic fixed, input fdsa_pkg::status_t fixed_status);
    int i;
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start           <= 1'b1;
    in_func         <= f;
    in_file_name    <= nm;
    in_sector_count <= cnt;
    do begin
      @(posedge clk);
    end while (busy);
    compute_sector_replies(f, nm, cnt);
    if (fixed)
      sector_replies.push_back('{'0, fixed_status, 1'b1});
    else
      for (i = 0; i < fresh_replies.size(); i++) sector_replies.push_back(fresh_replies[i]);
  endtask

  // result checker; the receiver never stalls
  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      if (sector_replies.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result: sector %0d status %0d last %0b",
                   out_sector, out_status, out_last);
      end else begin
        due = sector_replies.pop_front();
        if (out_sector !== due.sector || out_status !== due.status || out_last !== due.last)
        begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: want sector %0d status %0d last %0b, got %0d %0d %0b",
                     due.sector, due.status, due.last, out_sector, out_status, out_last);
        end
      end
    end
  end

  // watchdog: cycles with no transaction on either side
  always @(posedge clk) begin
    if ((start && !busy) || out_valid)
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  initial begin
    int s, j, p, k, idle_pct;
    logic f;
    logic [fdsa_pkg::NAME_W-1:0] nm;
    logic [fdsa_pkg::COUNT_W-1:0] cnt;

    // shadow state after reset: low sectors reserved, directory empty
    for (s = 0; s < MAP; s++) map_used[s] = (s < fdsa_pkg::RESERVED);
    for (s = 0; s < SLOTS; s++) begin
      slot_name[s] = '0;
      for (j = 0; j < LIST_LEN; j++) slot_list[s][j] = '0;
    end

    directed = '{
      // empty name hits slot 0
      '{fdsa_pkg::FUNC_LOOKUP, 48'h0000_0000_0000, 5'd0,  1'b1, fdsa_pkg::ST_NONE},
      '{fdsa_pkg::FUNC_LOOKUP, 48'h0000_0043_4241, 5'd0,  1'b1, fdsa_pkg::ST_NOT_FOUND},
      // count above list size
      '{fdsa_pkg::FUNC_CREATE, 48'h0000_0000_5A5A, 5'd31, 1'b1, fdsa_pkg::ST_NO_SPACE},
      '{fdsa_pkg::FUNC_CREATE, 48'h0000_0000_5A5A, 5'd27, 1'b1, fdsa_pkg::ST_NO_SPACE},
      // zero count fills a slot
      '{fdsa_pkg::FUNC_CREATE, 48'h0000_0000_0041, 5'd0,  1'b1, fdsa_pkg::ST_NONE},
      '{fdsa_pkg::FUNC_LOOKUP, 48'h0000_0000_0041, 5'd0,  1'b1, fdsa_pkg::ST_NONE},
      '{fdsa_pkg::FUNC_LOOKUP, 48'h0000_0000_0000, 5'd0,  1'b1, fdsa_pkg::ST_NONE},
      // largest file
      '{fdsa_pkg::FUNC_CREATE, 48'hFFFF_FFFF_FFFF, 5'd26, 1'b0, fdsa_pkg::ST_SECTOR},
      '{fdsa_pkg::FUNC_LOOKUP, 48'hFFFF_FFFF_FFFF, 5'd31, 1'b0, fdsa_pkg::ST_SECTOR},
      // prefix match
      '{fdsa_pkg::FUNC_LOOKUP, 48'h0000_0000_00FF, 5'd0,  1'b0, fdsa_pkg::ST_SECTOR},
      // empty name, sectors lost
      '{fdsa_pkg::FUNC_CREATE, 48'hFFFF_FFFF_FF00, 5'd5,  1'b0, fdsa_pkg::ST_SECTOR},
      '{fdsa_pkg::FUNC_CREATE, 48'h0000_0000_4241, 5'd1,  1'b0, fdsa_pkg::ST_SECTOR},
      '{fdsa_pkg::FUNC_LOOKUP, 48'h0000_0000_4241, 5'd0,  1'b0, fdsa_pkg::ST_SECTOR},
      // junk after zero byte
      '{fdsa_pkg::FUNC_LOOKUP, 48'h0000_5A5A_0041, 5'd0,  1'b0, fdsa_pkg::ST_SECTOR},
      // stored as "B" only
      '{fdsa_pkg::FUNC_CREATE, 48'h0000_4300_0042, 5'd3,  1'b0, fdsa_pkg::ST_SECTOR},
      '{fdsa_pkg::FUNC_LOOKUP, 48'h0000_0000_0042, 5'd0,  1'b0, fdsa_pkg::ST_SECTOR},
      '{fdsa_pkg::FUNC_LOOKUP, 48'h5A5A_5A5A_5A5A, 5'd0,  1'b1, fdsa_pkg::ST_NOT_FOUND},
      '{fdsa_pkg::FUNC_CREATE, 48'h8000_0000_0001, 5'd1,  1'b0, fdsa_pkg::ST_SECTOR}
    };

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (k = 0; k < DIRECTED_ROWS; k++)
      send_request(directed[k].func, directed[k].name, directed[k].count, 0,
                   directed[k].fixed, directed[k].status);

    // random phases; only the sender can idle, the receiver takes every result
    for (p = 0; p < 4; p++) begin
      idle_pct = (p == 1) ? 59 : (p == 3) ? 17 : 0;
      for (k = 0; k < PHASE_ITEMS; k++) begin
        pick_random_request(f, nm, cnt);
        send_request(f, nm, cnt, idle_pct, 1'b0, fdsa_pkg::ST_SECTOR);
      end
    end
    start <= 1'b0;

    while (sector_replies.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0)
      $display("All tests passed");
    else
      $display("Some tests failed");
    $finish;
  end

endmodule

// File: filelist.f
src/fdsa_pkg.sv
src/fdsa_dir.sv
src/fdsa_ctrl.sv
src/file_directory_sector_allocator_top.sv
tb/testbench.sv
